// ----- design/sti_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sti_pkg: shared types, constants and microprogram
// Holds the ALU request type, the state encodings, the register file map and
// the microprogram that the sequencer of the segment/triangle test runs.
// ---------------------------------------------------------------------------
package sti_pkg;

	// Field widths of the point and result channels.
	localparam int COORD_WIDTH_DEF = 16;
	localparam int FIELD_W         = 16;
	localparam int SLOT_W          = 3;
	localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd4;

	// Register file geometry.
	localparam int RF_DEPTH = 64;
	localparam int RF_AW    = 6;

	// Register file map. Slots 0..4 hold S, E, A, B and C as x, y, z triples.
	localparam int R_S   = 0;
	localparam int R_E   = 3;
	localparam int R_A   = 6;
	localparam int R_B   = 9;
	localparam int R_C   = 12;
	localparam int R_BA  = 15;
	localparam int R_CA  = 18;
	localparam int R_N   = 21;
	localparam int R_SA  = 24;
	localparam int R_EA  = 27;
	localparam int R_D1  = 30;
	localparam int R_D2  = 31;
	localparam int R_DEN = 32;
	localparam int R_DIR = 33;
	localparam int R_P   = 36;
	localparam int R_ED  = 39;
	localparam int R_CR  = 42;
	localparam int R_PF  = 45;
	localparam int R_T   = 48;

	typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MAC, ALU_DIV} alu_op_t;

	// Request to the shared ALU: operation, negate product, clear accumulator.
	typedef struct packed {
		alu_op_t op;
		logic    neg;
		logic    clr;
	} alu_req_t;

	typedef enum logic [2:0] {
		AS_IDLE, AS_MUL, AS_DIVN, AS_DIVD, AS_DIVI, AS_DIVF, AS_DONE
	} alu_state_t;

	typedef enum logic [2:0] {
		SQ_IDLE, SQ_WR, SQ_FETCH, SQ_ISSUE, SQ_WAIT, SQ_OUT
	} seq_state_t;

	typedef enum logic [1:0] {U_ALU, U_CHKD, U_CHKE, U_END} uop_t;

	typedef struct packed {
		uop_t             kind;
		alu_req_t         req;
		logic             wr;
		logic [RF_AW-1:0] ra;
		logic [RF_AW-1:0] rb;
		logic [RF_AW-1:0] rd;
	} instr_t;

	localparam int PROG_LEN = 87;
	localparam int PC_W     = 7;

	typedef instr_t [PROG_LEN-1:0] prog_t;

	function automatic instr_t mk(uop_t kind, alu_op_t op, int ra, int rb, int rd,
			logic neg, logic clr, logic wr);
		instr_t t;
		t.kind    = kind;
		t.req.op  = op;
		t.req.neg = neg;
		t.req.clr = clr;
		t.wr      = wr;
		t.ra      = RF_AW'(ra);
		t.rb      = RF_AW'(rb);
		t.rd      = RF_AW'(rd);
		return t;
	endfunction

	function automatic instr_t op_sub(int ra, int rb, int rd);
		return mk(U_ALU, ALU_SUB, ra, rb, rd, 1'b0, 1'b0, 1'b1);
	endfunction

	function automatic instr_t op_add(int ra, int rb, int rd);
		return mk(U_ALU, ALU_ADD, ra, rb, rd, 1'b0, 1'b0, 1'b1);
	endfunction

	function automatic instr_t op_div(int ra, int rb, int rd);
		return mk(U_ALU, ALU_DIV, ra, rb, rd, 1'b0, 1'b0, 1'b1);
	endfunction

	// Multiply-accumulate: ra is the short factor, rb the wide one.
	function automatic instr_t op_mac(int ra, int rb, int rd, logic neg, logic clr, logic wr);
		return mk(U_ALU, ALU_MAC, ra, rb, rd, neg, clr, wr);
	endfunction

	function automatic instr_t op_ctl(uop_t kind, int ra, int rb);
		return mk(kind, ALU_ADD, ra, rb, 0, 1'b0, 1'b0, 1'b0);
	endfunction

	// Builds the microprogram of the full test.
	function automatic prog_t build_prog();
		prog_t p;
		int    i;
		int    k1;
		int    k2;
		int    fb;
		int    tb;
		p = '0;
		i = 0;
		// Triangle edge vectors B-A and C-A.
		for (int k = 0; k < 3; k++) begin
			p[i] = op_sub(R_B + k, R_A + k, R_BA + k);
			i++;
		end
		for (int k = 0; k < 3; k++) begin
			p[i] = op_sub(R_C + k, R_A + k, R_CA + k);
			i++;
		end
		// Unnormalized normal n = (B-A) x (C-A).
		for (int k = 0; k < 3; k++) begin
			k1 = (k + 1) % 3;
			k2 = (k + 2) % 3;
			p[i]     = op_mac(R_BA + k1, R_CA + k2, R_N + k, 1'b0, 1'b1, 1'b0);
			p[i + 1] = op_mac(R_BA + k2, R_CA + k1, R_N + k, 1'b1, 1'b0, 1'b1);
			i += 2;
		end
		// Endpoint offsets from A and plane distances.
		for (int k = 0; k < 3; k++) begin
			p[i] = op_sub(R_S + k, R_A + k, R_SA + k);
			i++;
		end
		for (int k = 0; k < 3; k++) begin
			p[i] = op_sub(R_E + k, R_A + k, R_EA + k);
			i++;
		end
		for (int k = 0; k < 3; k++) begin
			p[i] = op_mac(R_SA + k, R_N + k, R_D1, 1'b0, k == 0, k == 2);
			i++;
		end
		for (int k = 0; k < 3; k++) begin
			p[i] = op_mac(R_EA + k, R_N + k, R_D2, 1'b0, k == 0, k == 2);
			i++;
		end
		p[i] = op_ctl(U_CHKD, R_D1, R_D2);
		i++;
		// Crossing point P = S + trunc(dir * -d1 / (d2 - d1)).
		p[i] = op_sub(R_D2, R_D1, R_DEN);
		i++;
		for (int k = 0; k < 3; k++) begin
			p[i] = op_sub(R_E + k, R_S + k, R_DIR + k);
			i++;
		end
		for (int k = 0; k < 3; k++) begin
			p[i]     = op_mac(R_DIR + k, R_D1, R_T, 1'b1, 1'b1, 1'b1);
			p[i + 1] = op_div(R_T, R_DEN, R_T);
			p[i + 2] = op_add(R_S + k, R_T, R_P + k);
			i += 3;
		end
		// Edge-side tests on A->B, B->C and C->A.
		for (int e = 0; e < 3; e++) begin
			fb = (e == 0) ? R_A : ((e == 1) ? R_B : R_C);
			tb = (e == 0) ? R_B : ((e == 1) ? R_C : R_A);
			for (int k = 0; k < 3; k++) begin
				p[i] = op_sub(tb + k, fb + k, R_ED + k);
				i++;
			end
			for (int k = 0; k < 3; k++) begin
				k1 = (k + 1) % 3;
				k2 = (k + 2) % 3;
				p[i]     = op_mac(R_ED + k2, R_N + k1, R_CR + k, 1'b0, 1'b1, 1'b0);
				p[i + 1] = op_mac(R_ED + k1, R_N + k2, R_CR + k, 1'b1, 1'b0, 1'b1);
				i += 2;
			end
			for (int k = 0; k < 3; k++) begin
				p[i] = op_sub(R_P + k, fb + k, R_PF + k);
				i++;
			end
			for (int k = 0; k < 3; k++) begin
				p[i] = op_mac(R_PF + k, R_CR + k, R_T, 1'b0, k == 0, k == 2);
				i++;
			end
			p[i] = op_ctl(U_CHKE, R_T, R_T);
			i++;
		end
		p[i] = op_ctl(U_END, 0, 0);
		return p;
	endfunction

	localparam prog_t PROG = build_prog();

endpackage
`default_nettype wire

// ----- design/sti_point_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sti_point_if: point channel
// Carries one 3D point and the store slot it goes to, with valid/ready.
// ---------------------------------------------------------------------------
interface sti_point_if;
	logic                              valid;
	logic                              ready;
	logic [sti_pkg::SLOT_W-1:0]        point_slot;
	logic signed [sti_pkg::FIELD_W-1:0] coord_x;
	logic signed [sti_pkg::FIELD_W-1:0] coord_y;
	logic signed [sti_pkg::FIELD_W-1:0] coord_z;

	modport source (output valid, point_slot, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, point_slot, coord_x, coord_y, coord_z, output ready);
endinterface
`default_nettype wire

// ----- design/sti_result_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sti_result_if: result channel
// Carries the hit flag and the crossing point, with valid/ready.
// ---------------------------------------------------------------------------
interface sti_result_if;
	logic                               valid;
	logic                               ready;
	logic                               hit;
	logic signed [sti_pkg::FIELD_W-1:0] hit_x;
	logic signed [sti_pkg::FIELD_W-1:0] hit_y;
	logic signed [sti_pkg::FIELD_W-1:0] hit_z;

	modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
	modport sink (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface
`default_nettype wire

// ----- design/sti_rf.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sti_rf: working register file
// One write port and two registered read ports. Entries that were never
// written since reset read as zero.
// ---------------------------------------------------------------------------
module sti_rf #(
	parameter int DATA_W = 72
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      we,
	input  wire logic [sti_pkg::RF_AW-1:0] waddr,
	input  wire logic [DATA_W-1:0]         wdata,
	input  wire logic [sti_pkg::RF_AW-1:0] raddr_a,
	input  wire logic [sti_pkg::RF_AW-1:0] raddr_b,
	output logic [DATA_W-1:0]              rdata_a,
	output logic [DATA_W-1:0]              rdata_b
);

	logic [DATA_W-1:0]            mem [sti_pkg::RF_DEPTH];
	logic [sti_pkg::RF_DEPTH-1:0] vld_q;
	logic [DATA_W-1:0]            rd_a_q;
	logic [DATA_W-1:0]            rd_b_q;
	logic                         va_q;
	logic                         vb_q;

	// Storage array and registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	// Written flags, cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			va_q <= vld_q[raddr_a];
			vb_q <= vld_q[raddr_b];
		end
	end

	assign rdata_a = va_q ? rd_a_q : '0;
	assign rdata_b = vb_q ? rd_b_q : '0;

endmodule
`default_nettype wire

// ----- design/sti_alu.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sti_alu: shared arithmetic unit
// One wide adder serves add, subtract, a bit-serial multiply-accumulate and
// a restoring divide that truncates toward zero.
// ---------------------------------------------------------------------------
module sti_alu #(
	parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sti_pkg::alu_req_t req,
	input  wire logic [4*COORD_WIDTH+7:0] opa,
	input  wire logic [4*COORD_WIDTH+7:0] opb,
	output logic                   done,
	output logic [4*COORD_WIDTH+7:0] result
);

	localparam int ACC_W = 4 * COORD_WIDTH + 8;
	localparam int SW    = COORD_WIDTH + 1;
	localparam int CNT_W = $clog2(ACC_W);

	sti_pkg::alu_state_t state_q, state_d;
	sti_pkg::alu_req_t   req_q;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    mcand_q;
	logic [SW-1:0]       mplier_q;
	logic [ACC_W-1:0]    num_q;
	logic [ACC_W-1:0]    den_q;
	logic [ACC_W-1:0]    rem_q;
	logic [ACC_W-1:0]    res_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                qneg_q;

	logic [ACC_W-1:0] add_x;
	logic [ACC_W-1:0] add_y;
	logic             add_sub;
	logic [ACC_W:0]   add_full;
	logic [ACC_W-1:0] sum;
	logic             carry;
	logic [ACC_W-1:0] rsh;
	logic             mul_last;
	logic             div_last;

	assign mul_last = (cnt_q == CNT_W'(SW - 1));
	assign div_last = (cnt_q == CNT_W'(ACC_W - 1));
	assign rsh      = {rem_q[ACC_W-2:0], num_q[ACC_W-1]};

	// The one shared adder.
	assign add_full = {1'b0, add_x} + {1'b0, add_y ^ {ACC_W{add_sub}}} + (ACC_W+1)'(add_sub);
	assign sum      = add_full[ACC_W-1:0];
	assign carry    = add_full[ACC_W];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sti_pkg::AS_IDLE: begin
				if (start) begin
					case (req.op)
						sti_pkg::ALU_MAC: state_d = sti_pkg::AS_MUL;
						sti_pkg::ALU_DIV: state_d = sti_pkg::AS_DIVN;
						default:          state_d = sti_pkg::AS_DONE;
					endcase
				end
			end
			sti_pkg::AS_MUL:  if (mul_last) state_d = sti_pkg::AS_DONE;
			sti_pkg::AS_DIVN: state_d = sti_pkg::AS_DIVD;
			sti_pkg::AS_DIVD: state_d = sti_pkg::AS_DIVI;
			sti_pkg::AS_DIVI: if (div_last) state_d = sti_pkg::AS_DIVF;
			sti_pkg::AS_DIVF: state_d = sti_pkg::AS_DONE;
			sti_pkg::AS_DONE: state_d = sti_pkg::AS_IDLE;
			default:          state_d = sti_pkg::AS_IDLE;
		endcase
	end

	// Adder operand selection and outputs.
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			sti_pkg::AS_IDLE: begin
				add_x   = opa;
				add_y   = opb;
				add_sub = (req.op == sti_pkg::ALU_SUB);
			end
			sti_pkg::AS_MUL: begin
				// The sign bit of the short factor carries negative weight.
				add_x   = acc_q;
				add_y   = mcand_q;
				add_sub = mul_last ^ req_q.neg;
			end
			sti_pkg::AS_DIVN, sti_pkg::AS_DIVF: begin
				add_y   = num_q;
				add_sub = 1'b1;
			end
			sti_pkg::AS_DIVD: begin
				add_y   = den_q;
				add_sub = 1'b1;
			end
			sti_pkg::AS_DIVI: begin
				add_x   = rsh;
				add_y   = den_q;
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	assign done   = (state_q == sti_pkg::AS_DONE);
	assign result = res_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sti_pkg::AS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sti_pkg::AS_IDLE: cnt_q <= '0;
				sti_pkg::AS_DIVD: cnt_q <= '0;
				sti_pkg::AS_MUL, sti_pkg::AS_DIVI: cnt_q <= cnt_q + 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			sti_pkg::AS_IDLE: begin
				if (start) begin
					req_q    <= req;
					mcand_q  <= opb;
					mplier_q <= opa[SW-1:0];
					num_q    <= opa;
					den_q    <= opb;
					qneg_q   <= opa[ACC_W-1] ^ opb[ACC_W-1];
					res_q    <= sum;
					if (req.op == sti_pkg::ALU_MAC && req.clr) begin
						acc_q <= '0;
					end
				end
			end
			sti_pkg::AS_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= sum;
				end
				if (mul_last) begin
					res_q <= mplier_q[0] ? sum : acc_q;
				end
				mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[SW-1:1]};
			end
			sti_pkg::AS_DIVN: begin
				if (num_q[ACC_W-1]) begin
					num_q <= sum;
				end
				rem_q <= '0;
			end
			sti_pkg::AS_DIVD: begin
				if (den_q[ACC_W-1]) begin
					den_q <= sum;
				end
			end
			sti_pkg::AS_DIVI: begin
				rem_q <= carry ? sum : rsh;
				num_q <= {num_q[ACC_W-2:0], carry};
			end
			sti_pkg::AS_DIVF: begin
				res_q <= qneg_q ? sum : num_q;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/segment_triangle_intersect.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// segment_triangle_intersect: segment / triangle crossing test
// Stores five points and, on the last triangle vertex, runs a microprogram
// on a shared ALU to find whether and where the segment crosses the triangle.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                               | transfer when
//  ---------+-----+---------------------------------------+----------------
//  point    | in  | point_slot, coord_x, coord_y, coord_z | valid & ready
//  result   | out | hit, hit_x, hit_y, hit_z              | valid & ready
//
// A point for slots 0..3 is stored as three coordinate writes; slots 5..7
// are dropped. The last vertex starts the microprogram, whose run time is
// set by the bit-serial multiply and divide.
// Misses found at the plane or edge checks end the program early.
// Reset clears all stored points to zero and empties the result register.
// A pending result does not block new points; the next test waits for it.
// ---------------------------------------------------------------------------
module segment_triangle_intersect #(
	parameter int COORD_WIDTH = sti_pkg::COORD_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sti_point_if.sink     point,
	sti_result_if.source  result
);

	localparam int ACC_W = 4 * COORD_WIDTH + 8;
	localparam int FW    = sti_pkg::FIELD_W;
	localparam int AW    = sti_pkg::RF_AW;

	sti_pkg::seq_state_t state_q, state_d;
	logic [sti_pkg::PC_W-1:0]   pc_q;
	logic [1:0]                 wcnt_q;
	logic [sti_pkg::SLOT_W-1:0] slot_q;
	logic [FW-1:0]              cx_q;
	logic [FW-1:0]              cy_q;
	logic [FW-1:0]              cz_q;
	logic                       hit_q;
	logic [FW-1:0]              px_q;
	logic [FW-1:0]              py_q;
	logic [FW-1:0]              pz_q;
	logic                       ov_q;
	logic                       ohit_q;
	logic [FW-1:0]              ox_q;
	logic [FW-1:0]              oy_q;
	logic [FW-1:0]              oz_q;

	sti_pkg::instr_t   instr;
	logic              accept;
	logic              rf_we;
	logic [AW-1:0]     rf_waddr;
	logic [ACC_W-1:0]  rf_wdata;
	logic [ACC_W-1:0]  rd_a;
	logic [ACC_W-1:0]  rd_b;
	logic              alu_start;
	logic              alu_done;
	logic [ACC_W-1:0]  alu_res;
	logic              miss_d;
	logic              neg_t;
	logic              load_out;
	logic [FW-1:0]               wfield;
	logic [FW+COORD_WIDTH-1:0]   wzext;
	logic [COORD_WIDTH-1:0]      wlow;

	assign instr  = sti_pkg::PROG[pc_q];
	assign accept = point.valid && point.ready;

	// Plane check: miss when either distance is zero or both share a sign.
	assign miss_d = (rd_a == '0) || (rd_b == '0) || (rd_a[ACC_W-1] == rd_b[ACC_W-1]);
	assign neg_t  = rd_a[ACC_W-1];

	// Coordinate written into the store, read as its low COORD_WIDTH bits.
	always_comb begin
		case (wcnt_q)
			2'd0:    wfield = cx_q;
			2'd1:    wfield = cy_q;
			default: wfield = cz_q;
		endcase
	end
	assign wzext = {{COORD_WIDTH{1'b0}}, wfield};
	assign wlow  = wzext[COORD_WIDTH-1:0];

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sti_pkg::SQ_IDLE: begin
				if (accept && point.point_slot <= sti_pkg::LAST_SLOT) begin
					state_d = sti_pkg::SQ_WR;
				end
			end
			sti_pkg::SQ_WR: begin
				if (wcnt_q == 2'd2) begin
					state_d = (slot_q == sti_pkg::LAST_SLOT) ? sti_pkg::SQ_FETCH
					                                         : sti_pkg::SQ_IDLE;
				end
			end
			sti_pkg::SQ_FETCH: state_d = sti_pkg::SQ_ISSUE;
			sti_pkg::SQ_ISSUE: begin
				case (instr.kind)
					sti_pkg::U_ALU:  state_d = sti_pkg::SQ_WAIT;
					sti_pkg::U_CHKD: state_d = miss_d ? sti_pkg::SQ_OUT : sti_pkg::SQ_FETCH;
					sti_pkg::U_CHKE: state_d = neg_t ? sti_pkg::SQ_OUT : sti_pkg::SQ_FETCH;
					default:         state_d = sti_pkg::SQ_OUT;
				endcase
			end
			sti_pkg::SQ_WAIT: if (alu_done) state_d = sti_pkg::SQ_FETCH;
			sti_pkg::SQ_OUT:  if (load_out) state_d = sti_pkg::SQ_IDLE;
			default:          state_d = sti_pkg::SQ_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		point.ready = 1'b0;
		rf_we       = 1'b0;
		rf_waddr    = '0;
		rf_wdata    = alu_res;
		alu_start   = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			sti_pkg::SQ_IDLE: point.ready = 1'b1;
			sti_pkg::SQ_WR: begin
				rf_we    = 1'b1;
				rf_waddr = AW'({slot_q, 1'b0}) + AW'(slot_q) + AW'(wcnt_q);
				rf_wdata = ACC_W'($signed(wlow));
			end
			sti_pkg::SQ_ISSUE: alu_start = (instr.kind == sti_pkg::U_ALU);
			sti_pkg::SQ_WAIT: begin
				rf_we    = alu_done && instr.wr;
				rf_waddr = instr.rd;
			end
			sti_pkg::SQ_OUT: load_out = !ov_q || result.ready;
			default: rf_we = 1'b0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sti_pkg::SQ_IDLE;
			pc_q    <= '0;
			wcnt_q  <= '0;
			hit_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sti_pkg::SQ_IDLE: begin
					wcnt_q <= '0;
					pc_q   <= '0;
				end
				sti_pkg::SQ_WR: wcnt_q <= wcnt_q + 1'b1;
				sti_pkg::SQ_ISSUE: begin
					case (instr.kind)
						sti_pkg::U_CHKD: begin
							hit_q <= 1'b0;
							if (!miss_d) pc_q <= pc_q + 1'b1;
						end
						sti_pkg::U_CHKE: begin
							hit_q <= 1'b0;
							if (!neg_t) pc_q <= pc_q + 1'b1;
						end
						sti_pkg::U_END: hit_q <= 1'b1;
						default: pc_q <= pc_q;
					endcase
				end
				sti_pkg::SQ_WAIT: if (alu_done) pc_q <= pc_q + 1'b1;
				default: pc_q <= pc_q;
			endcase
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Payload registers: input hold, crossing point capture and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q <= point.point_slot;
			cx_q   <= point.coord_x;
			cy_q   <= point.coord_y;
			cz_q   <= point.coord_z;
		end
		if (rf_we && rf_waddr == AW'(sti_pkg::R_P)) px_q <= rf_wdata[FW-1:0];
		if (rf_we && rf_waddr == AW'(sti_pkg::R_P + 1)) py_q <= rf_wdata[FW-1:0];
		if (rf_we && rf_waddr == AW'(sti_pkg::R_P + 2)) pz_q <= rf_wdata[FW-1:0];
		if (load_out) begin
			ohit_q <= hit_q;
			ox_q   <= hit_q ? px_q : '0;
			oy_q   <= hit_q ? py_q : '0;
			oz_q   <= hit_q ? pz_q : '0;
		end
	end

	assign result.valid = ov_q;
	assign result.hit   = ohit_q;
	assign result.hit_x = ox_q;
	assign result.hit_y = oy_q;
	assign result.hit_z = oz_q;

	sti_rf #(
		.DATA_W (ACC_W)
	) u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.raddr_a (instr.ra),
		.raddr_b (instr.rb),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	sti_alu #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.req    (instr.req),
		.opa    (rd_a),
		.opb    (rd_b),
		.done   (alu_done),
		.result (alu_res)
	);

endmodule
`default_nettype wire

// ----- design/sti_chk.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// sti_chk: port checker
// Watches the point and result channels of the top level over time.
// ---------------------------------------------------------------------------
module sti_chk (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_ready,
	input wire logic [sti_pkg::SLOT_W-1:0]        in_slot,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic                              out_hit,
	input wire logic [sti_pkg::FIELD_W-1:0]       out_x,
	input wire logic [sti_pkg::FIELD_W-1:0]       out_y,
	input wire logic [sti_pkg::FIELD_W-1:0]       out_z
);

	// The last vertex starts a test, so the block stops taking points.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_slot == sti_pkg::LAST_SLOT |=> !in_ready)
		else $error("point accepted right after the last vertex");

	// A miss reports a zero crossing point.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_hit |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("miss carries a nonzero point");

	// Any other point never produces a result on the next cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_slot != sti_pkg::LAST_SLOT && !out_valid |=> !out_valid)
		else $error("result without a last vertex");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_x)
			&& $stable(out_y) && $stable(out_z))
		else $error("stalled result changed");

endmodule

bind segment_triangle_intersect sti_chk u_sti_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point.valid),
	.in_ready  (point.ready),
	.in_slot   (point.point_slot),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_hit   (result.hit),
	.out_x     (result.hit_x),
	.out_y     (result.hit_y),
	.out_z     (result.hit_z)
);
`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tb: self-checking bench for segment_triangle_intersect
// Sends well-formed five-point sequences (segment ends, then triangle
// vertices), broken sequences and ignored slots. Both channels idle at random.
// Each accepted point for slots 0..4 updates a local copy of the point store.
// A point in the last slot also yields an expected hit flag and crossing
// point, which are compared with each result transfer in order.
// ---------------------------------------------------------------------------
module tb;

	localparam int  LIMIT_CYCLES = 10000000;
	localparam int  DRAIN_CYCLES = 1500;

	typedef logic signed [127:0] wide_t;
	typedef wide_t vec_t [3];

	typedef struct {
		logic [sti_pkg::SLOT_W-1:0]         slot;
		logic signed [sti_pkg::FIELD_W-1:0] x;
		logic signed [sti_pkg::FIELD_W-1:0] y;
		logic signed [sti_pkg::FIELD_W-1:0] z;
		logic                               hold;
	} point_t;

	typedef struct {
		logic                               hit;
		logic signed [sti_pkg::FIELD_W-1:0] x;
		logic signed [sti_pkg::FIELD_W-1:0] y;
		logic signed [sti_pkg::FIELD_W-1:0] z;
	} crossing_t;

	logic clk;
	logic arst_n;

	sti_point_if  pt();
	sti_result_if rs();

	segment_triangle_intersect u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.point  (pt),
		.result (rs)
	);

	point_t    pending_points[$];
	crossing_t expected_crossings[$];
	wide_t     point_store[15];
	int        errors;
	int        cycles;
	int        send_gap;
	int        recv_gap;
	logic      point_taken;
	logic      busy_mode;

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report(input string what);
		errors++;
		$display("ERROR at cycle %0d: %s", cycles, what);
	endtask

	function automatic vec_t vsub(vec_t a, vec_t b);
		vec_t r;
		for (int k = 0; k < 3; k++) r[k] = a[k] - b[k];
		return r;
	endfunction

	function automatic vec_t vcross(vec_t a, vec_t b);
		vec_t r;
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
		return r;
	endfunction

	function automatic wide_t vdot(vec_t a, vec_t b);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	function automatic vec_t stored(int slot);
		vec_t r;
		for (int k = 0; k < 3; k++) r[k] = point_store[slot * 3 + k];
		return r;
	endfunction

	// Crossing test on the stored points, in exact integer arithmetic.
	function automatic crossing_t find_crossing();
		crossing_t c;
		vec_t      s, e, a, b, cv, n, dir, p;
		vec_t      corner[3];
		wide_t     d1, d2, den;
		c = '{1'b0, '0, '0, '0};
		s = stored(0);
		e = stored(1);
		a = stored(2);
		b = stored(3);
		cv = stored(4);
		n = vcross(vsub(b, a), vsub(cv, a));
		d1 = vdot(vsub(s, a), n);
		d2 = vdot(vsub(e, a), n);
		if (d1 == 0 || d2 == 0 || ((d1 < 0) == (d2 < 0))) return c;
		den = d2 - d1;
		dir = vsub(e, s);
		for (int k = 0; k < 3; k++) p[k] = s[k] + (dir[k] * (-d1)) / den;
		corner[0] = a;
		corner[1] = b;
		corner[2] = cv;
		for (int j = 0; j < 3; j++) begin
			if (vdot(vcross(n, vsub(corner[(j + 1) % 3], corner[j])),
					vsub(p, corner[j])) < 0)
				return c;
		end
		c.hit = 1'b1;
		c.x = p[0][sti_pkg::FIELD_W-1:0];
		c.y = p[1][sti_pkg::FIELD_W-1:0];
		c.z = p[2][sti_pkg::FIELD_W-1:0];
		return c;
	endfunction

	// Applies one accepted point to the local store.
	task automatic take_point(input logic [sti_pkg::SLOT_W-1:0] slot,
			input logic signed [sti_pkg::FIELD_W-1:0] x,
			input logic signed [sti_pkg::FIELD_W-1:0] y,
			input logic signed [sti_pkg::FIELD_W-1:0] z);
		if (slot > sti_pkg::LAST_SLOT) return;
		point_store[slot * 3]     = x;
		point_store[slot * 3 + 1] = y;
		point_store[slot * 3 + 2] = z;
		if (slot == sti_pkg::LAST_SLOT) expected_crossings.push_back(find_crossing());
	endtask

	task automatic add_point(input int slot, input int x, input int y, input int z);
		point_t p;
		p.slot = (sti_pkg::SLOT_W)'(slot);
		p.x = (sti_pkg::FIELD_W)'(x);
		p.y = (sti_pkg::FIELD_W)'(y);
		p.z = (sti_pkg::FIELD_W)'(z);
		p.hold = 1'b0;
		pending_points.push_back(p);
	endtask

	function automatic int rand_coord(int span);
		return $signed($urandom_range(2 * span, 0)) - span;
	endfunction

	function automatic int draw_gap();
		return busy_mode ? 0 : $urandom_range(18, 0);
	endfunction

	// Reset and idle values.
	initial begin
		arst_n = 1'b0;
		pt.valid = 1'b0;
		pt.point_slot = '0;
		pt.coord_x = '0;
		pt.coord_y = '0;
		pt.coord_z = '0;
		rs.ready = 1'b0;
		errors = 0;
		cycles = 0;
		send_gap = 0;
		recv_gap = 0;
		point_taken = 1'b0;
		busy_mode = 1'b0;
		for (int k = 0; k < 15; k++) point_store[k] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
	end

	// Stimulus and end of run.
	initial begin
		int sent;
		int cx, cy, cz, span;
		int ax, ay, az, bx, by, bz, qx, qy, qz, px, py, pz, ux, uy, uz;
		// Last vertex with nothing else written: degenerate triangle.
		add_point(4, 0, 0, 0);
		// Clean crossing at the origin.
		add_point(0, 0, 0, 10);
		add_point(1, 0, 0, -10);
		add_point(2, -10, -10, 0);
		add_point(3, 10, -10, 0);
		add_point(4, 0, 10, 0);
		// Crossing exactly at a vertex, then on an edge.
		add_point(0, -10, -10, 5);
		add_point(1, -10, -10, -5);
		add_point(4, 0, 10, 0);
		add_point(0, 0, -10, 7);
		add_point(1, 0, -10, -3);
		add_point(4, 0, 10, 0);
		// Both ends on one side, then one end on the plane.
		add_point(1, 0, 0, 3);
		add_point(4, 0, 10, 0);
		add_point(1, 0, 0, 0);
		add_point(4, 0, 10, 0);
		// Ignored slots.
		add_point(5, -1, -1, -1);
		add_point(6, 32767, -32768, 0);
		add_point(7, -32768, 32767, 21845);
		// Coordinate extremes.
		add_point(0, 32767, 32767, 32767);
		add_point(1, -32768, -32768, -32768);
		add_point(2, -32768, 32767, -32768);
		add_point(3, 32767, -32768, -32768);
		add_point(4, 0, 0, 32767);
		pending_points[pending_points.size() - 1].hold = 1'b1;

		sent = pending_points.size();
		while (sent < 1650) begin
			if ($urandom_range(9, 0) < 2) begin
				// Noise: a single point to any slot.
				add_point($urandom_range(7, 0), rand_coord(32768), rand_coord(32768),
					rand_coord(32768));
				sent++;
			end else if ($urandom_range(1, 0) == 0) begin
				// Random points, any range.
				span = ($urandom_range(3, 0) == 0) ? 32767 : $urandom_range(2000, 1);
				for (int s = 0; s < 5; s++)
					add_point(s, rand_coord(span), rand_coord(span), rand_coord(span));
				sent += 5;
			end else begin
				// Segment through a point near the triangle centroid.
				span = ($urandom_range(3, 0) == 0) ? 10000 : $urandom_range(300, 3);
				ax = rand_coord(span); ay = rand_coord(span); az = rand_coord(span);
				bx = rand_coord(span); by = rand_coord(span); bz = rand_coord(span);
				qx = rand_coord(span); qy = rand_coord(span); qz = rand_coord(span);
				px = (ax + bx + qx) / 3 + rand_coord(span / 4);
				py = (ay + by + qy) / 3 + rand_coord(span / 4);
				pz = (az + bz + qz) / 3 + rand_coord(span / 4);
				ux = rand_coord(span); uy = rand_coord(span); uz = rand_coord(span);
				cx = $urandom_range(2, 1);
				add_point(0, px + ux, py + uy, pz + uz);
				add_point(1, px - cx * ux, py - cx * uy, pz - cx * uz);
				add_point(2, ax, ay, az);
				add_point(3, bx, by, bz);
				add_point(4, qx, qy, qz);
				sent += 5;
			end
			if (sent > 800 && sent < 806)
				pending_points[pending_points.size() - 1].hold = 1'b1;
		end

		while (pending_points.size() != 0 || pt.valid) @(posedge clk);
		while (expected_crossings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("segment_triangle_intersect: match");
		end else begin
			$display("segment_triangle_intersect: mismatch");
		end
		$finish;
	end

	// Point driver: presents queued points with random gaps between them.
	always @(negedge clk) begin
		logic   keep;
		point_t p;
		if (arst_n) begin
			keep = pt.valid && !point_taken;
			if (!keep) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (send_gap == 0 && pending_points.size() != 0) begin
					p = pending_points.pop_front();
					pt.point_slot <= p.slot;
					pt.coord_x <= p.x;
					pt.coord_y <= p.y;
					pt.coord_z <= p.z;
					keep = 1'b1;
					if ($urandom_range(99, 0) == 0) busy_mode = ~busy_mode;
					send_gap = draw_gap();
					// Hold-off: wait for every result before the next point.
					if (p.hold) send_gap = -1;
				end
			end
			if (send_gap < 0 && !keep && expected_crossings.size() == 0) send_gap = 0;
			pt.valid <= keep;
			point_taken = 1'b0;
			rs.ready <= (recv_gap == 0);
			if (recv_gap > 0) recv_gap--;
		end
	end

	// Monitor: accepted points feed the store, results are checked in order.
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("segment_triangle_intersect: mismatch");
				$finish;
			end
			if (pt.valid && pt.ready) begin
				point_taken = 1'b1;
				take_point(pt.point_slot, pt.coord_x, pt.coord_y, pt.coord_z);
			end
			if (rs.valid && rs.ready) begin
				recv_gap = draw_gap();
				if (expected_crossings.size() == 0) begin
					report("result transfer with no result expected");
				end else begin
					want = expected_crossings.pop_front();
					if (rs.hit !== want.hit)
						report($sformatf("hit %b, expected %b", rs.hit, want.hit));
					if (rs.hit_x !== want.x)
						report($sformatf("hit_x %0d, expected %0d", rs.hit_x, want.x));
					if (rs.hit_y !== want.y)
						report($sformatf("hit_y %0d, expected %0d", rs.hit_y, want.y));
					if (rs.hit_z !== want.z)
						report($sformatf("hit_z %0d, expected %0d", rs.hit_z, want.z));
				end
			end
		end
	end

endmodule
`default_nettype wire
